/* hdl/vector3_arithmetic_unit_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef VECTOR3_ARITHMETIC_UNIT_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define V3AU_ASSERT_NOW(label, ante, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define V3AU_ASSERT_NEXT(label, ante, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (conseq)) \
        else $error(msg);

`endif

/* hdl/v3au_pkg.sv */
`timescale 1ns / 1ps

package v3au_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int KIND_BITS  = 4;
    localparam int LANES      = 3;
    localparam int MULTS      = 6;
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int SAT_W      = PROD_W + 2;
    localparam int DIVIDEND_W = WORD_BITS + FRAC_BITS;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int REM_W      = WORD_BITS + 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [KIND_BITS-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_CMP   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_MAG   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    // Per-item sideband carried down the whole pipeline.
    typedef struct packed {
        op_t                              kind;
        logic [LANES-1:0][WORD_BITS-1:0]  vec;
        logic [WORD_BITS-1:0]             scalar;
        logic                             eq;
        logic                             clip;
        logic                             zdiv;
        logic [LANES-1:0]                 neg;
    } item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 clip;
    } sat_t;

    // Clip a wide signed value to the signed word range.
    function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
        sat_t                        r;
        logic [SAT_W-WORD_BITS:0]    hi_bits;
        hi_bits = v[SAT_W-1:WORD_BITS-1];
        if ((&hi_bits) || !(|hi_bits))
        begin
            r.val  = v[WORD_BITS-1:0];
            r.clip = 1'b0;
        end
        else
        begin
            r.val  = v[SAT_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                : {1'b0, {(WORD_BITS-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

/* hdl/v3au_front.sv */
`timescale 1ns / 1ps

module v3au_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [v3au_pkg::KIND_BITS-1:0]         kind,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_x,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_y,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_z,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_x,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_y,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_z,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  scalar_in,
    output logic                                   valid,
    output v3au_pkg::item_t                        item,
    output logic [v3au_pkg::PROD_W-1:0]            radicand
);
    import v3au_pkg::*;

    op_t                         op;
    word_t                       a [LANES];
    word_t                       b [LANES];
    word_t                       mx_next [MULTS];
    word_t                       my_next [MULTS];
    item_t                       item1_next;
    logic signed [WORD_BITS:0]   sum1;
    sat_t                        st1;

    logic                        vld1_reg, vld2_reg, vld3_reg;
    word_t                       mx_reg [MULTS];
    word_t                       my_reg [MULTS];
    item_t                       item1_reg, item2_reg, item3_reg;
    logic signed [PROD_W-1:0]    prod_reg [MULTS];
    logic [PROD_W-1:0]           rad3_reg;

    item_t                       item3_next;
    logic [PROD_W-1:0]           rad3_next;
    logic signed [SAT_W-1:0]     wide3;
    sat_t                        st3;

    // Stage 1: operand steering, add/sub and compare.
    always_comb
    begin
        op = op_t'(kind);
        a[0] = a_x;  a[1] = a_y;  a[2] = a_z;
        b[0] = b_x;  b[1] = b_y;  b[2] = b_z;
        item1_next      = '0;
        item1_next.kind = op;
        sum1            = '0;
        st1             = '0;
        for (int m = 0; m < MULTS; m++)
        begin
            mx_next[m] = '0;
            my_next[m] = '0;
        end
        case (op)
            OP_ADD, OP_SUB:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (op == OP_ADD)
                        sum1 = (WORD_BITS+1)'(a[l]) + (WORD_BITS+1)'(b[l]);
                    else
                        sum1 = (WORD_BITS+1)'(a[l]) - (WORD_BITS+1)'(b[l]);
                    st1 = sat_word(SAT_W'(sum1));
                    item1_next.vec[l] = st1.val;
                    item1_next.clip   = item1_next.clip | st1.clip;
                end
            end
            OP_SCALE:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx_next[l] = a[l];
                    my_next[l] = scalar_in;
                end
            end
            OP_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                    item1_next.vec[l] = a[l];
                item1_next.scalar = scalar_in;
            end
            OP_CMP:
                item1_next.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            OP_DOT:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx_next[l] = a[l];
                    my_next[l] = b[l];
                end
            end
            OP_CROSS:
            begin
                // lane l: a[j]*b[k] - a[k]*b[j]
                mx_next[0] = a[1];  my_next[0] = b[2];
                mx_next[1] = a[2];  my_next[1] = b[0];
                mx_next[2] = a[0];  my_next[2] = b[1];
                mx_next[3] = a[2];  my_next[3] = b[1];
                mx_next[4] = a[0];  my_next[4] = b[2];
                mx_next[5] = a[1];  my_next[5] = b[0];
            end
            OP_MAG, OP_NORM:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx_next[l] = b[l];
                    my_next[l] = b[l];
                    item1_next.vec[l] = b[l];
                end
            end
            default: ;
        endcase
    end

    // Stage 3: reduce products, shift out the fraction, clip; magnitude and normalize only sum the squares.
    always_comb
    begin
        item3_next = item2_reg;
        rad3_next  = '0;
        wide3      = '0;
        st3        = '0;
        case (item2_reg.kind)
            OP_SCALE:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    wide3 = SAT_W'(prod_reg[l]);
                    st3   = sat_word(wide3 >>> FRAC_BITS);
                    item3_next.vec[l] = st3.val;
                    item3_next.clip   = item3_next.clip | st3.clip;
                end
            end
            OP_DOT:
            begin
                wide3 = SAT_W'(prod_reg[0]) + SAT_W'(prod_reg[1]) + SAT_W'(prod_reg[2]);
                st3   = sat_word(wide3 >>> FRAC_BITS);
                item3_next.scalar = st3.val;
                item3_next.clip   = st3.clip;
            end
            OP_CROSS:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    wide3 = SAT_W'(prod_reg[l]) - SAT_W'(prod_reg[l+LANES]);
                    st3   = sat_word(wide3 >>> FRAC_BITS);
                    item3_next.vec[l] = st3.val;
                    item3_next.clip   = item3_next.clip | st3.clip;
                end
            end
            OP_MAG, OP_NORM:
                rad3_next = prod_reg[0] + prod_reg[1] + prod_reg[2];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < MULTS; m++)
            begin
                mx_reg[m]   <= mx_next[m];
                my_reg[m]   <= my_next[m];
                prod_reg[m] <= PROD_W'(mx_reg[m]) * PROD_W'(my_reg[m]);
            end
            item1_reg <= item1_next;
            item2_reg <= item1_reg;
            item3_reg <= item3_next;
            rad3_reg  <= rad3_next;
        end
    end

    assign valid    = vld3_reg;
    assign item     = item3_reg;
    assign radicand = rad3_reg;

endmodule

/* hdl/v3au_sqrt.sv */
`timescale 1ns / 1ps

module v3au_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  v3au_pkg::item_t                    in_item,
    input  logic [v3au_pkg::PROD_W-1:0]        radicand,
    output logic                               out_valid,
    output v3au_pkg::item_t                    out_item,
    output logic [v3au_pkg::WORD_BITS-1:0]     root
);
    import v3au_pkg::*;

    logic [SQRT_STEPS-1:0]   vld_reg;
    item_t                   item_reg [SQRT_STEPS];
    logic [PROD_W-1:0]       rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]        rem_reg  [SQRT_STEPS];
    logic [WORD_BITS-1:0]    root_reg [SQRT_STEPS];

    // One root bit per stage: bring in two radicand bits, try 4*root+1.
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_step
        logic                  vld_in;
        item_t                 item_in;
        logic [PROD_W-1:0]     rad_in;
        logic [REM_W-1:0]      rem_in;
        logic [WORD_BITS-1:0]  root_in;
        logic [REM_W-1:0]      rem_sh, trial, rem_next;
        logic [WORD_BITS-1:0]  root_next;

        if (g == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign item_in = in_item;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[g-1];
            assign item_in = item_reg[g-1];
            assign rad_in  = rad_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[WORD_BITS-1:0], rad_in[PROD_W-1:PROD_W-2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[WORD_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (adv)
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                item_reg[g] <= item_in;
                rad_reg[g]  <= {rad_in[PROD_W-3:0], 2'b00};
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_item  = item_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];

endmodule

/* hdl/v3au_div.sv */
`timescale 1ns / 1ps

module v3au_div (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  logic                                                       adv,
    input  logic                                                       in_valid,
    input  v3au_pkg::item_t                                            in_item,
    input  logic [v3au_pkg::LANES-1:0][v3au_pkg::DIVIDEND_W-1:0]       dividend,
    input  logic [v3au_pkg::WORD_BITS-1:0]                             divisor,
    output logic                                                       out_valid,
    output v3au_pkg::item_t                                            out_item,
    output logic [v3au_pkg::LANES-1:0][v3au_pkg::DIVIDEND_W-1:0]       quotient
);
    import v3au_pkg::*;

    logic [DIV_STEPS-1:0]                     vld_reg;
    item_t                                    item_reg [DIV_STEPS];
    logic [WORD_BITS-1:0]                     den_reg  [DIV_STEPS];
    logic [LANES-1:0][DIVIDEND_W-1:0]         dq_reg   [DIV_STEPS];
    logic [LANES-1:0][WORD_BITS-1:0]          rem_reg  [DIV_STEPS];

    // Restoring division, one quotient bit per stage; quotient bits shift
    // in where dividend bits shift out.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        logic                              vld_in;
        item_t                             item_in;
        logic [WORD_BITS-1:0]              den_in;
        logic [LANES-1:0][DIVIDEND_W-1:0]  dq_in, dq_next;
        logic [LANES-1:0][WORD_BITS-1:0]   rem_in, rem_next;
        logic [WORD_BITS:0]                rem_sh [LANES];
        logic [WORD_BITS:0]                diff   [LANES];
        logic [LANES-1:0]                  ge;

        if (g == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign item_in = in_item;
            assign den_in  = divisor;
            assign dq_in   = dividend;
            assign rem_in  = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[g-1];
            assign item_in = item_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign dq_in   = dq_reg[g-1];
            assign rem_in  = rem_reg[g-1];
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh[l] = {rem_in[l], dq_in[l][DIVIDEND_W-1]};
                diff[l]   = rem_sh[l] - {1'b0, den_in};
                ge[l]     = (rem_sh[l] >= {1'b0, den_in});
                rem_next[l] = ge[l] ? diff[l][WORD_BITS-1:0] : rem_sh[l][WORD_BITS-1:0];
                dq_next[l]  = {dq_in[l][DIVIDEND_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (adv)
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                item_reg[g] <= item_in;
                den_reg[g]  <= den_in;
                dq_reg[g]   <= dq_next;
                rem_reg[g]  <= rem_next;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_item  = item_reg[DIV_STEPS-1];
    assign quotient  = dq_reg[DIV_STEPS-1];

endmodule

/* hdl/vector3_arithmetic_unit.sv */
// Three-component vector unit in signed Q16.16: add, subtract, scale,
// divide by scalar, compare, dot, cross, magnitude and normalize of b, with
// every result clipped to 32 bits. It takes one word per clock while
// in_ready is high and returns each result in order; the path is three
// front stages (operand steering, multiply, reduce), a 32-stage square-root
// pipeline and a 48-stage divider, plus the output register, and every
// operation runs the full length. When the output word is not taken the
// whole pipeline holds and in_ready drops; with out_ready high the rate is one word per cycle.
`timescale 1ns / 1ps

module vector3_arithmetic_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [v3au_pkg::KIND_BITS-1:0]         kind,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_x,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_y,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  a_z,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_x,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_y,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  b_z,
    input  logic signed [v3au_pkg::WORD_BITS-1:0]  scalar_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [v3au_pkg::WORD_BITS-1:0]  r_x,
    output logic signed [v3au_pkg::WORD_BITS-1:0]  r_y,
    output logic signed [v3au_pkg::WORD_BITS-1:0]  r_z,
    output logic signed [v3au_pkg::WORD_BITS-1:0]  scalar_out,
    output logic                                   equal_flag,
    output logic                                   zero_divisor,
    output logic                                   saturated
);
    import v3au_pkg::*;

    logic                               adv;
    logic                               f_valid, s_valid, d_valid;
    item_t                              f_item, s_item, p_item, d_item;
    logic [PROD_W-1:0]                  f_rad;
    logic [WORD_BITS-1:0]               s_root;
    logic [LANES-1:0][DIVIDEND_W-1:0]   p_dividend, d_quot;
    logic [WORD_BITS-1:0]               p_divisor;
    logic                               is_div;
    logic [WORD_BITS-1:0]               num_mag;
    sat_t                               p_st;

    logic [LANES-1:0][WORD_BITS-1:0]    vec_next;
    logic [WORD_BITS-1:0]               sc_next;
    logic                               eq_next, zdiv_next, clip_next;
    logic signed [DIVIDEND_W:0]         q_abs, q_val;
    sat_t                               q_st;

    logic                               out_valid_reg;
    logic [LANES-1:0][WORD_BITS-1:0]    vec_reg;
    logic [WORD_BITS-1:0]               sc_reg;
    logic                               eq_reg, zdiv_reg, clip_reg;

    // Advance everything while the output register is free or being drained.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    v3au_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .kind      (kind),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .scalar_in (scalar_in),
        .valid     (f_valid),
        .item      (f_item),
        .radicand  (f_rad)
    );

    v3au_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .radicand  (f_rad),
        .out_valid (s_valid),
        .out_item  (s_item),
        .root      (s_root)
    );

    // Pick divisor, split numerators into sign and magnitude, clip magnitude.
    always_comb
    begin
        p_item    = s_item;
        is_div    = (s_item.kind == OP_DIV);
        num_mag   = '0;
        p_st      = '0;
        p_divisor = s_root;
        if (is_div)
            p_divisor = s_item.scalar[WORD_BITS-1] ? (~s_item.scalar + 1'b1)
                                                    : s_item.scalar;
        for (int l = 0; l < LANES; l++)
        begin
            num_mag = s_item.vec[l][WORD_BITS-1] ? (~s_item.vec[l] + 1'b1) : s_item.vec[l];
            p_dividend[l] = {num_mag, {FRAC_BITS{1'b0}}};
            p_item.neg[l] = s_item.vec[l][WORD_BITS-1] ^ (is_div & s_item.scalar[WORD_BITS-1]);
        end
        p_item.zdiv = (is_div || (s_item.kind == OP_NORM)) && (p_divisor == '0);
        if (s_item.kind == OP_MAG)
        begin
            p_st          = sat_word(SAT_W'({1'b0, s_root}));
            p_item.scalar = p_st.val;
            p_item.clip   = p_st.clip;
        end
    end

    v3au_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_item   (p_item),
        .dividend  (p_dividend),
        .divisor   (p_divisor),
        .out_valid (d_valid),
        .out_item  (d_item),
        .quotient  (d_quot)
    );

    // Assemble the result word; fields an operation does not produce are zero.
    always_comb
    begin
        vec_next  = '0;
        sc_next   = '0;
        eq_next   = 1'b0;
        zdiv_next = 1'b0;
        clip_next = d_item.clip;
        q_abs     = '0;
        q_val     = '0;
        q_st      = '0;
        case (d_item.kind)
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS:
                vec_next = d_item.vec;
            OP_DIV, OP_NORM:
            begin
                zdiv_next = d_item.zdiv;
                if (d_item.zdiv)
                begin
                    if (d_item.kind == OP_DIV)
                        vec_next = d_item.vec;
                end
                else
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        q_abs = {1'b0, d_quot[l]};
                        q_val = d_item.neg[l] ? -q_abs : q_abs;
                        q_st  = sat_word(SAT_W'(q_val));
                        vec_next[l] = q_st.val;
                        clip_next   = clip_next | q_st.clip;
                    end
                end
            end
            OP_CMP:
                eq_next = d_item.eq;
            OP_DOT, OP_MAG:
                sc_next = d_item.scalar;
            default:
                clip_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            sc_reg   <= sc_next;
            eq_reg   <= eq_next;
            zdiv_reg <= zdiv_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign r_x          = vec_reg[0];
    assign r_y          = vec_reg[1];
    assign r_z          = vec_reg[2];
    assign scalar_out   = sc_reg;
    assign equal_flag   = eq_reg;
    assign zero_divisor = zdiv_reg;
    assign saturated    = clip_reg;

endmodule

/* hdl/v3au_checker.sv */
`timescale 1ns / 1ps
`include "vector3_arithmetic_unit_macros.svh"

module v3au_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [v3au_pkg::WORD_BITS-1:0]  r_x,
    input logic signed [v3au_pkg::WORD_BITS-1:0]  r_y,
    input logic signed [v3au_pkg::WORD_BITS-1:0]  r_z,
    input logic signed [v3au_pkg::WORD_BITS-1:0]  scalar_out,
    input logic                                   equal_flag,
    input logic                                   zero_divisor,
    input logic                                   saturated
);
    import v3au_pkg::*;

    `V3AU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(r_x) && $stable(scalar_out) && $stable(saturated), "result word changed while stalled")

    `V3AU_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

    `V3AU_ASSERT_NOW(a_flags_exclusive, out_valid, !(equal_flag && zero_divisor), "compare and zero divisor flags both set")

    // Compare yields only the flag.
    `V3AU_ASSERT_NOW(a_cmp_clean, out_valid && equal_flag, r_x == 0 && r_y == 0 && r_z == 0 && scalar_out == 0 && !saturated, "compare word carries data")

    `V3AU_ASSERT_NOW(a_zdiv_clean, out_valid && zero_divisor, scalar_out == 0 && !saturated, "zero divisor word carries scalar or clip")

endmodule

bind vector3_arithmetic_unit v3au_checker u_v3au_checker (.*);
